### design/bankers_deadlock_avoidance_assert.svh
// assertion macros
`ifndef BANKERS_DEADLOCK_AVOIDANCE_ASSERT_SVH
`define BANKERS_DEADLOCK_AVOIDANCE_ASSERT_SVH
`ifndef SYNTH
`define BDA_ASSERT_IMP(lbl, ante, cons) lbl: assert property (@(posedge clk) \
  disable iff (!rst_n) (ante) |-> (cons)) else $error("bda check failed");
`define BDA_ASSERT_NXT(lbl, ante, cons) lbl: assert property (@(posedge clk) \
  disable iff (!rst_n) (ante) |=> (cons)) else $error("bda check failed");
`else
`define BDA_ASSERT_IMP(lbl, ante, cons)
`define BDA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### design/bda_pkg.sv
`default_nettype none
package bda_pkg;

  localparam logic [1:0] FN_AVAIL  = 2'd0;
  localparam logic [1:0] FN_CLAIM  = 2'd1;
  localparam logic [1:0] FN_REQ    = 2'd2;
  localparam logic [1:0] FN_FINISH = 2'd3;

  localparam logic [1:0] RS_GRANTED  = 2'd0;
  localparam logic [1:0] RS_NO_AVAIL = 2'd1;
  localparam logic [1:0] RS_NO_NEED  = 2'd2;
  localparam logic [1:0] RS_UNSAFE   = 2'd3;

  localparam logic CFG_REQ_COUNT = 1'b0;
  localparam logic CFG_RES_COUNT = 1'b1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_FIN, S_CHK, S_APPLY, S_SCAN, S_FIT, S_GIVE, S_UNDO, S_ZERO, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_FINISH, OP_CHECK, OP_APPLY, OP_UNDO, OP_ZERO, OP_FIT, OP_GIVE
  } op_t;

  typedef struct packed {
    logic clr_step;
    logic wr_avail;
    logic wr_claim;
    logic wr_req;
    logic set_fin;
    logic sw_start;
    op_t  sw_op;
    logic res_init;
    logic res_bad;
    logic res_unsafe;
    logic work_init;
    logic i_clr;
    logic i_inc;
    logic mark_visit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic r_ok;
    logic sw_done;
    logic st_ok;
    logic fits;
    logic i_end;
    logic skip_i;
    logic progress;
    logic safe;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### design/bda_ram.sv
`default_nettype none
module bda_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### design/bda_ctrl.sv
`default_nettype none
module bda_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_func,
  input  wire logic          in_last,
  input  wire bda_pkg::sts_t sts,
  output bda_pkg::cmd_t      cmd,
  output logic               in_ready
);
  bda_pkg::state_t state_r, state_nxt;
  logic acc;

  assign in_ready = (state_r == bda_pkg::S_IDLE);
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bda_pkg::S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      bda_pkg::S_CLR: begin
        if (sts.clr_done) begin
          state_nxt = bda_pkg::S_IDLE;
        end else begin
          cmd.clr_step = 1'b1;
        end
      end
      bda_pkg::S_IDLE: begin
        if (acc) begin
          case (in_func)
            bda_pkg::FN_AVAIL: cmd.wr_avail = 1'b1;
            bda_pkg::FN_CLAIM: cmd.wr_claim = 1'b1;
            bda_pkg::FN_FINISH: begin
              if (sts.r_ok) begin
                cmd.set_fin  = 1'b1;
                cmd.sw_start = 1'b1;
                cmd.sw_op    = bda_pkg::OP_FINISH;
                state_nxt    = bda_pkg::S_FIN;
              end
            end
            bda_pkg::FN_REQ: begin
              cmd.wr_req = 1'b1;
              if (in_last) begin
                if (sts.r_ok) begin
                  cmd.res_init = 1'b1;
                  cmd.sw_start = 1'b1;
                  cmd.sw_op    = bda_pkg::OP_CHECK;
                  state_nxt    = bda_pkg::S_CHK;
                end else begin
                  cmd.res_bad = 1'b1;
                  state_nxt   = bda_pkg::S_OUT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      bda_pkg::S_FIN: begin
        if (sts.sw_done) state_nxt = bda_pkg::S_IDLE;
      end
      bda_pkg::S_CHK: begin
        if (sts.sw_done) begin
          cmd.sw_start = 1'b1;
          if (sts.st_ok) begin
            cmd.sw_op = bda_pkg::OP_APPLY;
            state_nxt = bda_pkg::S_APPLY;
          end else begin
            cmd.sw_op = bda_pkg::OP_ZERO;
            state_nxt = bda_pkg::S_ZERO;
          end
        end
      end
      bda_pkg::S_APPLY: begin
        if (sts.sw_done) begin
          cmd.work_init = 1'b1;
          state_nxt     = bda_pkg::S_SCAN;
        end
      end
      bda_pkg::S_SCAN: begin
        if (sts.i_end) begin
          if (sts.progress) begin
            cmd.i_clr = 1'b1;
          end else if (sts.safe) begin
            cmd.sw_start = 1'b1;
            cmd.sw_op    = bda_pkg::OP_ZERO;
            state_nxt    = bda_pkg::S_ZERO;
          end else begin
            cmd.res_unsafe = 1'b1;
            cmd.sw_start   = 1'b1;
            cmd.sw_op      = bda_pkg::OP_UNDO;
            state_nxt      = bda_pkg::S_UNDO;
          end
        end else if (sts.skip_i) begin
          cmd.i_inc = 1'b1;
        end else begin
          cmd.sw_start = 1'b1;
          cmd.sw_op    = bda_pkg::OP_FIT;
          state_nxt    = bda_pkg::S_FIT;
        end
      end
      bda_pkg::S_FIT: begin
        if (sts.sw_done) begin
          if (sts.fits) begin
            cmd.mark_visit = 1'b1;
            cmd.sw_start   = 1'b1;
            cmd.sw_op      = bda_pkg::OP_GIVE;
            state_nxt      = bda_pkg::S_GIVE;
          end else begin
            cmd.i_inc = 1'b1;
            state_nxt = bda_pkg::S_SCAN;
          end
        end
      end
      bda_pkg::S_GIVE: begin
        if (sts.sw_done) begin
          cmd.i_inc = 1'b1;
          state_nxt = bda_pkg::S_SCAN;
        end
      end
      bda_pkg::S_UNDO: begin
        if (sts.sw_done) begin
          cmd.sw_start = 1'b1;
          cmd.sw_op    = bda_pkg::OP_ZERO;
          state_nxt    = bda_pkg::S_ZERO;
        end
      end
      bda_pkg::S_ZERO: begin
        if (sts.sw_done) state_nxt = bda_pkg::S_OUT;
      end
      bda_pkg::S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = bda_pkg::S_IDLE;
        end
      end
      default: state_nxt = bda_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### design/bda_dp.sv
`default_nettype none
module bda_dp #(
  parameter int MAX_REQUESTERS = 16,
  parameter int MAX_RESOURCES  = 8,
  parameter int AMOUNT_WIDTH   = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bda_pkg::cmd_t cmd,
  output bda_pkg::sts_t      sts,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [4:0]    cfg_data,
  input  wire logic [3:0]    in_requester,
  input  wire logic [2:0]    in_res_index,
  input  wire logic [15:0]   in_amount,
  input  wire logic          out_ready,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic               out_need_done
);
  localparam int RW    = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
  localparam int CW    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int QW    = $clog2(MAX_REQUESTERS + 1);
  localparam int JW    = $clog2(MAX_RESOURCES + 1);
  localparam int AW    = RW + CW;
  localparam int DEPTH = MAX_REQUESTERS * (2 ** CW);
  localparam int CLW   = $clog2(DEPTH + 1);
  localparam int MW    = 2 * AMOUNT_WIDTH;

  function automatic logic [AMOUNT_WIDTH-1:0] sat_add(input logic [AMOUNT_WIDTH-1:0] a,
                                                      input logic [AMOUNT_WIDTH-1:0] b);
    logic [AMOUNT_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AMOUNT_WIDTH] ? {AMOUNT_WIDTH{1'b1}} : s[AMOUNT_WIDTH-1:0];
  endfunction

  logic [4:0]              req_cnt_r;
  logic [3:0]              res_cnt_r;
  logic [AMOUNT_WIDTH-1:0] avail_r [MAX_RESOURCES];
  logic [AMOUNT_WIDTH-1:0] work_r  [MAX_RESOURCES];
  logic [AMOUNT_WIDTH-1:0] reqb_r  [MAX_RESOURCES];
  logic [MAX_REQUESTERS-1:0] finished_r, visited_r;
  logic [RW-1:0]   r_r;
  logic [QW-1:0]   i_r;
  bda_pkg::op_t    op_r;
  logic            run_r, pv_r;
  logic [JW-1:0]   j_r;
  logic [CW-1:0]   jd_r;
  logic [CLW-1:0]  clr_r;
  logic [1:0]      st_r;
  logic            nz_r, fits_r, prog_r;
  logic            out_valid_r, out_nd_r;
  logic [1:0]      out_status_r;

  logic [QW-1:0]   nq;
  logic [JW-1:0]   nr, lim;
  logic            r_ok, c_ok, issue, wb;
  logic [RW-1:0]   in_row, i_idx, row;
  logic [CW-1:0]   in_col;
  logic [AMOUNT_WIDTH-1:0] amt, rd_alloc, rd_need, req_d, av_d, wk_d;
  logic [MW-1:0]   rdata, wdata, wb_data;
  logic [AW-1:0]   waddr, raddr;
  logic            we;
  logic [MAX_REQUESTERS-1:0] pend;

  assign nq = (32'(req_cnt_r) > MAX_REQUESTERS) ? QW'(MAX_REQUESTERS) : QW'(req_cnt_r);
  assign nr = (32'(res_cnt_r) > MAX_RESOURCES) ? JW'(MAX_RESOURCES) : JW'(res_cnt_r);
  assign r_ok   = 32'(in_requester) < 32'(nq);
  assign c_ok   = 32'(in_res_index) < MAX_RESOURCES;
  assign in_row = RW'(in_requester);
  assign in_col = CW'(in_res_index);
  assign amt    = AMOUNT_WIDTH'(in_amount);
  assign i_idx  = i_r[RW-1:0];
  assign row    = (op_r == bda_pkg::OP_FIT || op_r == bda_pkg::OP_GIVE) ? i_idx : r_r;
  assign lim    = (op_r == bda_pkg::OP_FINISH) ? JW'(MAX_RESOURCES) : nr;
  assign issue  = run_r && (j_r < lim);
  assign raddr  = {row, j_r[CW-1:0]};

  assign rd_alloc = rdata[MW-1:AMOUNT_WIDTH];
  assign rd_need  = rdata[AMOUNT_WIDTH-1:0];
  assign req_d    = reqb_r[jd_r];
  assign av_d     = avail_r[jd_r];
  assign wk_d     = work_r[jd_r];

  always_comb begin
    wb      = 1'b0;
    wb_data = rdata;
    case (op_r)
      bda_pkg::OP_FINISH: begin
        wb      = pv_r;
        wb_data = {{AMOUNT_WIDTH{1'b0}}, rd_need};
      end
      bda_pkg::OP_APPLY: begin
        wb      = pv_r;
        wb_data = {rd_alloc + req_d, rd_need - req_d};
      end
      bda_pkg::OP_UNDO: begin
        wb      = pv_r;
        wb_data = {rd_alloc - req_d, rd_need + req_d};
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = clr_r[AW-1:0];
      wdata = '0;
    end else if (cmd.wr_claim) begin
      we    = r_ok && c_ok;
      waddr = {in_row, in_col};
      wdata = {{AMOUNT_WIDTH{1'b0}}, amt};
    end else begin
      we    = wb;
      waddr = {row, jd_r};
      wdata = wb_data;
    end
  end

  bda_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    for (int k = 0; k < MAX_REQUESTERS; k++) begin
      pend[k] = !finished_r[k] && !visited_r[k] && (32'(k) < 32'(nq));
    end
  end

  assign sts.clr_done = (clr_r == CLW'(DEPTH));
  assign sts.r_ok     = r_ok;
  assign sts.sw_done  = !run_r && !pv_r;
  assign sts.st_ok    = (st_r == bda_pkg::RS_GRANTED);
  assign sts.fits     = fits_r;
  assign sts.i_end    = (i_r >= nq);
  assign sts.skip_i   = visited_r[i_idx] | finished_r[i_idx];
  assign sts.progress = prog_r;
  assign sts.safe     = ~|pend;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_need_done = out_nd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_cnt_r   <= 5'd16;
      res_cnt_r   <= 4'd8;
      finished_r  <= '0;
      visited_r   <= '0;
      run_r       <= 1'b0;
      pv_r        <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      prog_r      <= 1'b0;
      for (int k = 0; k < MAX_RESOURCES; k++) begin
        avail_r[k] <= '0;
        reqb_r[k]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bda_pkg::CFG_REQ_COUNT: req_cnt_r <= cfg_data;
          bda_pkg::CFG_RES_COUNT: res_cnt_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cmd.wr_avail && c_ok) avail_r[in_col] <= amt;
      if (cmd.wr_req && c_ok) reqb_r[in_col] <= amt;
      if (cmd.set_fin) finished_r[in_row] <= 1'b1;
      if (cmd.wr_req || cmd.set_fin) r_r <= in_row;

      pv_r <= issue;
      jd_r <= j_r[CW-1:0];
      if (cmd.sw_start) begin
        op_r  <= cmd.sw_op;
        run_r <= 1'b1;
        j_r   <= '0;
        if (cmd.sw_op == bda_pkg::OP_FIT) fits_r <= 1'b1;
        if (cmd.sw_op == bda_pkg::OP_ZERO) nz_r <= 1'b0;
      end else if (run_r) begin
        if (issue) begin
          j_r <= j_r + 1'b1;
        end else begin
          run_r <= 1'b0;
        end
      end

      if (pv_r) begin
        case (op_r)
          bda_pkg::OP_FINISH: avail_r[jd_r] <= sat_add(av_d, rd_alloc);
          bda_pkg::OP_APPLY:  avail_r[jd_r] <= av_d - req_d;
          bda_pkg::OP_UNDO:   avail_r[jd_r] <= av_d + req_d;
          bda_pkg::OP_CHECK: begin
            if (st_r == bda_pkg::RS_GRANTED) begin
              if (req_d > rd_need) begin
                st_r <= bda_pkg::RS_NO_NEED;
              end else if (req_d > av_d) begin
                st_r <= bda_pkg::RS_NO_AVAIL;
              end
            end
          end
          bda_pkg::OP_ZERO: if (rd_need != '0) nz_r <= 1'b1;
          bda_pkg::OP_FIT:  if (rd_need > wk_d) fits_r <= 1'b0;
          bda_pkg::OP_GIVE: work_r[jd_r] <= sat_add(wk_d, rd_alloc);
          default: ;
        endcase
      end

      if (cmd.res_init) st_r <= bda_pkg::RS_GRANTED;
      if (cmd.res_bad) begin
        st_r <= bda_pkg::RS_NO_NEED;
        nz_r <= 1'b1;
      end
      if (cmd.res_unsafe) st_r <= bda_pkg::RS_UNSAFE;

      if (cmd.work_init) begin
        for (int k = 0; k < MAX_RESOURCES; k++) work_r[k] <= avail_r[k];
        visited_r <= '0;
        i_r       <= '0;
        prog_r    <= 1'b0;
      end
      if (cmd.i_clr) begin
        i_r    <= '0;
        prog_r <= 1'b0;
      end
      if (cmd.i_inc) i_r <= i_r + 1'b1;
      if (cmd.mark_visit) begin
        visited_r[i_idx] <= 1'b1;
        prog_r           <= 1'b1;
      end

      if (cmd.out_load) begin
        out_valid_r  <= 1'b1;
        out_status_r <= st_r;
        out_nd_r     <= !nz_r;
        for (int k = 0; k < MAX_RESOURCES; k++) reqb_r[k] <= '0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

### design/bankers_deadlock_avoidance.sv
// Load, claim and non-last request items are handled in the idle state; finish sweeps all
// MAX_RESOURCES columns of its row. A last request element runs a check sweep; if it passes,
// an update sweep, a safety pass of up to R*(R+1)/2 fit sweeps and R give sweeps, an undo sweep
// when unsafe, and then a need sweep, which a failed check goes to directly.
// After reset the RAM is cleared one entry a cycle (MAX_REQUESTERS*2^ceil(log2 MAX_RESOURCES)
// entries) before the first request is taken; configuration writes are taken throughout.
`default_nettype none
`include "bankers_deadlock_avoidance_assert.svh"
module bankers_deadlock_avoidance #(
  parameter int MAX_REQUESTERS = 16,
  parameter int MAX_RESOURCES  = 8,
  parameter int AMOUNT_WIDTH   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [3:0]  in_requester,
  input  wire logic [2:0]  in_res_index,
  input  wire logic [15:0] in_amount,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic             out_need_done
);
  bda_pkg::cmd_t cmd;
  bda_pkg::sts_t sts;

  bda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_last  (in_last),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  bda_dp #(
    .MAX_REQUESTERS (MAX_REQUESTERS),
    .MAX_RESOURCES  (MAX_RESOURCES),
    .AMOUNT_WIDTH   (AMOUNT_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_requester  (in_requester),
    .in_res_index  (in_res_index),
    .in_amount     (in_amount),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_need_done (out_need_done)
  );

  `BDA_ASSERT_NXT(a_eval_busy, in_valid && in_ready && in_func == bda_pkg::FN_REQ && in_last, !in_ready)
  `BDA_ASSERT_NXT(a_avail_quick, in_valid && in_ready && in_func == bda_pkg::FN_AVAIL, in_ready)
  `BDA_ASSERT_IMP(a_load_busy, $rose(out_valid), !$past(in_ready))
endmodule
`default_nettype wire

### verif/bankers_deadlock_avoidance_tb.sv
`default_nettype none
module bankers_deadlock_avoidance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NQ = 16;
  localparam int NR = 8;
  localparam logic [15:0] AMT_MAX = 16'hFFFF;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  requester;
    logic [2:0]  res_index;
    logic [15:0] amount;
    logic        last;
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    logic       need_done;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [4:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_func = '0;
  logic [3:0] in_requester = '0;
  logic [2:0] in_res_index = '0;
  logic [15:0] in_amount = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic out_need_done;

  bankers_deadlock_avoidance dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_requester(in_requester), .in_res_index(in_res_index), .in_amount(in_amount),
    .in_last(in_last), .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_need_done(out_need_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  int unsigned req_cnt, res_cnt;
  logic [15:0] avail_m [NR];
  logic [15:0] alloc_m [NQ][NR];
  logic [15:0] need_m  [NQ][NR];
  logic        fin_m   [NQ];
  logic [15:0] pend_m  [NR];

  request_t pending_requests[$];
  verdict_t expected_verdicts[$];
  int errors = 0;
  bit quiet = 0;
  bit stim_done = 0;

  // the handshake seen at the last rising edge decides whether the request went
  logic in_ready_q = 1'b0;
  int idle_cycles = 0;

  function automatic logic [15:0] sat_sum(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? AMT_MAX : s[15:0];
  endfunction

  function automatic int unsigned nq_used();
    return req_cnt > NQ ? NQ : req_cnt;
  endfunction

  function automatic int unsigned nr_used();
    return res_cnt > NR ? NR : res_cnt;
  endfunction

  function automatic bit state_is_safe();
    logic [15:0] wk [NR];
    bit seen [NQ];
    int unsigned rest, done, nq, nr;
    bit progress, fits;
    nq = nq_used();
    nr = nr_used();
    rest = 0;
    done = 0;
    progress = 1;
    for (int j = 0; j < nr; j++) wk[j] = avail_m[j];
    for (int i = 0; i < NQ; i++) seen[i] = 0;
    for (int i = 0; i < nq; i++) if (!fin_m[i]) rest++;
    while (done < rest && progress) begin
      progress = 0;
      for (int i = 0; i < nq; i++) begin
        if (seen[i] || fin_m[i]) continue;
        fits = 1;
        for (int j = 0; j < nr; j++) if (need_m[i][j] > wk[j]) fits = 0;
        if (fits) begin
          progress = 1;
          seen[i] = 1;
          done++;
          for (int j = 0; j < nr; j++) wk[j] = sat_sum(wk[j], alloc_m[i][j]);
        end
      end
    end
    return done == rest;
  endfunction

  function automatic void apply_request(request_t q);
    int unsigned r, c, nr;
    verdict_t v;
    bit zero;
    r = q.requester;
    c = q.res_index;
    nr = nr_used();
    case (q.func)
      bda_pkg::FN_AVAIL: avail_m[c] = q.amount;
      bda_pkg::FN_CLAIM: if (r < nq_used()) begin
        need_m[r][c] = q.amount;
        alloc_m[r][c] = '0;
      end
      bda_pkg::FN_FINISH: if (r < nq_used()) begin
        fin_m[r] = 1;
        for (int j = 0; j < NR; j++) begin
          avail_m[j] = sat_sum(avail_m[j], alloc_m[r][j]);
          alloc_m[r][j] = '0;
        end
      end
      default: begin
        pend_m[c] = q.amount;
        if (q.last) begin
          if (r < nq_used()) begin
            v.status = bda_pkg::RS_GRANTED;
            for (int j = 0; j < nr; j++) begin
              if (pend_m[j] > need_m[r][j]) begin v.status = bda_pkg::RS_NO_NEED; break; end
              if (pend_m[j] > avail_m[j]) begin v.status = bda_pkg::RS_NO_AVAIL; break; end
            end
            if (v.status == bda_pkg::RS_GRANTED) begin
              for (int j = 0; j < nr; j++) begin
                avail_m[j] -= pend_m[j];
                alloc_m[r][j] += pend_m[j];
                need_m[r][j] -= pend_m[j];
              end
              if (!state_is_safe()) begin
                for (int j = 0; j < nr; j++) begin
                  avail_m[j] += pend_m[j];
                  alloc_m[r][j] -= pend_m[j];
                  need_m[r][j] += pend_m[j];
                end
                v.status = bda_pkg::RS_UNSAFE;
              end
            end
            zero = 1;
            for (int j = 0; j < nr; j++) if (need_m[r][j] != 0) zero = 0;
            v.need_done = zero;
          end else begin
            v.status = bda_pkg::RS_NO_NEED;
            v.need_done = 1'b0;
          end
          expected_verdicts = {expected_verdicts, v};
          for (int j = 0; j < NR; j++) pend_m[j] = '0;
        end
      end
    endcase
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_ready_q)) begin
      if (pending_requests.size() != 0 && (quiet || $urandom_range(99) >= 15)) begin
        request_t q;
        q = pending_requests.pop_front();
        in_valid <= 1'b1;
        in_func <= q.func;
        in_requester <= q.requester;
        in_res_index <= q.res_index;
        in_amount <= q.amount;
        in_last <= q.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_ready_q <= in_valid && in_ready ? 1'b1 : 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready)
        apply_request('{in_func, in_requester, in_res_index, in_amount, in_last});
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          errors++;
          $display("%0t: unexpected result status=%0d need_done=%0d", $realtime,
                   out_status, out_need_done);
        end else begin
          verdict_t e;
          e = expected_verdicts.pop_front();
          if (e.status !== out_status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $realtime, e.status, out_status);
          end
          if (e.need_done !== out_need_done) begin
            errors++;
            $display("%0t: need_done expected %0d actual %0d", $realtime, e.need_done,
                     out_need_done);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("bankers_deadlock_avoidance verification failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n && (quiet || $urandom_range(99) >= 15);
  end

  task automatic push_req(logic [1:0] f, int r, int c, int a, bit l);
    request_t q;
    q.func = f;
    q.requester = r[3:0];
    q.res_index = c[2:0];
    q.amount = a[15:0];
    q.last = l;
    pending_requests = {pending_requests, q};
  endtask

  task automatic drain();
    while (pending_requests.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, int v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[4:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == bda_pkg::CFG_REQ_COUNT) req_cnt = v[4:0];
    else req_cnt = req_cnt;
    if (idx == bda_pkg::CFG_RES_COUNT) res_cnt = v[3:0];
  endtask

  task automatic random_phase(int n);
    int r, c;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(NQ - 1);
      case ($urandom_range(9))
        0: push_req(bda_pkg::FN_AVAIL, $urandom, $urandom_range(NR - 1),
                    $urandom_range(1) ? $urandom_range(40) : $urandom, 1'b0);
        1, 2: push_req(bda_pkg::FN_CLAIM, r, $urandom_range(NR - 1),
                       $urandom_range(3) ? $urandom_range(20) : $urandom, 1'($urandom));
        3: push_req(bda_pkg::FN_FINISH, r, $urandom, $urandom, 1'($urandom));
        default: begin
          c = $urandom_range(1, 3);
          for (int j = 0; j < c; j++)
            push_req(bda_pkg::FN_REQ, r, $urandom_range(NR - 1),
                     $urandom_range(7) ? $urandom_range(12) : $urandom, j == c - 1);
          k += c - 1;
        end
      endcase
    end
  endtask

  initial begin
    req_cnt = 16;
    res_cnt = 8;
    for (int j = 0; j < NR; j++) begin
      avail_m[j] = '0;
      pend_m[j] = '0;
    end
    for (int i = 0; i < NQ; i++) begin
      fin_m[i] = 0;
      for (int j = 0; j < NR; j++) begin
        alloc_m[i][j] = '0;
        need_m[i][j] = '0;
      end
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed
    for (int j = 0; j < NR; j++) push_req(bda_pkg::FN_AVAIL, 0, j, 10, 0);
    push_req(bda_pkg::FN_AVAIL, 15, 7, 16'hFFFF, 1);
    push_req(bda_pkg::FN_CLAIM, 0, 0, 5, 0);
    push_req(bda_pkg::FN_CLAIM, 1, 0, 16'hFFFF, 0);
    push_req(bda_pkg::FN_REQ, 0, 0, 6, 1);
    push_req(bda_pkg::FN_REQ, 0, 0, 5, 1);
    push_req(bda_pkg::FN_REQ, 1, 0, 7, 1);
    push_req(bda_pkg::FN_REQ, 1, 0, 6, 1);
    push_req(bda_pkg::FN_FINISH, 0, 0, 0, 0);
    push_req(bda_pkg::FN_FINISH, 0, 0, 0, 1);
    push_req(bda_pkg::FN_REQ, 0, 3, 0, 1);
    push_req(bda_pkg::FN_REQ, 1, 7, 16'hFFFF, 0);
    push_req(bda_pkg::FN_REQ, 1, 0, 3, 1);
    drain();

    write_cfg(bda_pkg::CFG_REQ_COUNT, 3);
    write_cfg(bda_pkg::CFG_RES_COUNT, 2);
    push_req(bda_pkg::FN_CLAIM, 5, 0, 3, 0);
    push_req(bda_pkg::FN_FINISH, 5, 0, 0, 0);
    push_req(bda_pkg::FN_REQ, 5, 0, 1, 1);
    push_req(bda_pkg::FN_CLAIM, 2, 1, 30, 0);
    push_req(bda_pkg::FN_REQ, 2, 1, 4, 1);
    random_phase(60);
    drain();

    write_cfg(bda_pkg::CFG_REQ_COUNT, 1);
    write_cfg(bda_pkg::CFG_RES_COUNT, 1);
    random_phase(40);
    drain();

    write_cfg(bda_pkg::CFG_REQ_COUNT, 31);
    write_cfg(bda_pkg::CFG_RES_COUNT, 15);
    quiet = 1;
    random_phase(60);
    drain();
    quiet = 0;

    write_cfg(bda_pkg::CFG_REQ_COUNT, 0);
    write_cfg(bda_pkg::CFG_RES_COUNT, 0);
    random_phase(20);
    drain();

    write_cfg(bda_pkg::CFG_REQ_COUNT, 6);
    write_cfg(bda_pkg::CFG_RES_COUNT, 4);
    random_phase(90);
    drain();

    if (errors == 0)
      $display("bankers_deadlock_avoidance verification clean");
    else
      $display("bankers_deadlock_avoidance verification failed");
    $finish;
  end
endmodule
`default_nettype wire
